### hdl/bf_pkg.sv
// Shared types and constants for the shortest path block.
`timescale 1ns / 1ps
`default_nettype none

package bf_pkg;

    // Node count register and node field widths are fixed by the interface.
    localparam int NODE_CW = 7;
    localparam int NODE_FW = 6;
    localparam int WEIGHT_W = 16;

    // Packed edge word: source, target, weight.
    localparam int EDGE_W = 2 * NODE_FW + WEIGHT_W;
    localparam int SRC_LSB = NODE_FW + WEIGHT_W;
    localparam int DST_LSB = WEIGHT_W;

    // Distance entry: valid bit on top of a 32-bit signed distance.
    localparam int DIST_VW = 32;
    localparam int DIST_W = DIST_VW + 1;
    localparam logic [DIST_VW-1:0] DIST_MAX = 32'h7fff_ffff;
    localparam logic [DIST_VW-1:0] DIST_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        S_LOAD,
        S_INIT,
        S_FETCH,
        S_DREAD,
        S_UPDATE,
        S_ORD,
        S_OLOAD,
        S_SEND
    } state_t;

    typedef struct packed {
        logic                 relax;
        logic [DIST_VW-1:0]   cand;
    } relax_t;

endpackage

`default_nettype wire

### hdl/bf_edge_mem.sv
// Edge store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bf_edge_mem
    import bf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW = 10
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [EDGE_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [EDGE_W-1:0] rd_data
);

    logic [EDGE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/bf_dist_mem.sv
// Distance store: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module bf_dist_mem
    import bf_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DIST_W-1:0] wr_data,
    input  wire logic [AW-1:0]     rd_addr_a,
    input  wire logic [AW-1:0]     rd_addr_b,
    output logic      [DIST_W-1:0] rd_data_a,
    output logic      [DIST_W-1:0] rd_data_b
);

    logic [DIST_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

### hdl/bf_relax.sv
// Relaxation of one edge: saturating candidate distance and improvement test.
`timescale 1ns / 1ps
`default_nettype none

module bf_relax
    import bf_pkg::*;
(
    input  wire logic [EDGE_W-1:0]  edge_word,
    input  wire logic [DIST_W-1:0]  dist_src,
    input  wire logic [DIST_W-1:0]  dist_dst,
    input  wire logic [NODE_CW-1:0] nodes,
    output relax_t                  result
);

    logic [NODE_FW-1:0]  src;
    logic [NODE_FW-1:0]  dst;
    logic [WEIGHT_W-1:0] w;
    logic [DIST_VW:0]    sum;
    logic [DIST_VW-1:0]  cand;
    logic                skip;

    always_comb
    begin
        src = edge_word[SRC_LSB +: NODE_FW];
        dst = edge_word[DST_LSB +: NODE_FW];
        w = edge_word[WEIGHT_W-1:0];
        sum = {dist_src[DIST_VW-1], dist_src[DIST_VW-1:0]}
            + {{(DIST_VW + 1 - WEIGHT_W){w[WEIGHT_W-1]}}, w};
        // The top two bits disagree only when the 32-bit range is left.
        if (sum[DIST_VW] != sum[DIST_VW-1])
        begin
            cand = sum[DIST_VW] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand = sum[DIST_VW-1:0];
        end
        skip = ({1'b0, src} >= nodes) || ({1'b0, dst} >= nodes) || !dist_src[DIST_VW];
        result.cand = cand;
        result.relax = !skip && (!dist_dst[DIST_VW]
            || ($signed(cand) < $signed(dist_dst[DIST_VW-1:0])));
    end

endmodule

`default_nettype wire

### hdl/bellman_ford_negative_cycle.sv
// Loading accepts one edge request per cycle. A run then sets up the distance of one node in
// use per cycle and makes up to one pass per node; each stored edge goes through an edge read,
// a distance read and an update, as both stores have registered reads; the check pass stops at
// an edge that still relaxes. A result goes through a distance read, a result load and a send
// that waits for out_ready, a cycle report only the send. Reset clears control state and
// sets the node count register to 64; both stores are left undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module bellman_ford_negative_cycle
    import bf_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 1024
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [NODE_CW-1:0]  cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [NODE_FW-1:0]  edge_source,
    input  wire logic [NODE_FW-1:0]  edge_target,
    input  wire logic signed [WEIGHT_W-1:0] edge_weight,
    input  wire logic                last_edge,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [NODE_FW-1:0]       node_index,
    output logic signed [DIST_VW-1:0] distance,
    output logic                     reachable,
    output logic                     negative_cycle,
    output logic                     edges_dropped,
    output logic                     last_result
);

    localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);

    state_t state_reg, state_next;

    logic [NODE_CW-1:0] node_count_reg, node_count_next;
    logic [NODE_CW-1:0] nodes_reg, nodes_next;
    logic [NODE_CW-1:0] k_reg, k_next;
    logic [NODE_CW-1:0] pass_reg, pass_next;
    logic [ECW-1:0]     edge_total_reg, edge_total_next;
    logic [ECW-1:0]     e_reg, e_next;
    logic               overflow_reg, overflow_next;

    logic [NODE_FW-1:0] node_index_reg, node_index_next;
    logic [DIST_VW-1:0] distance_reg, distance_next;
    logic               reachable_reg, reachable_next;
    logic               cycle_reg, cycle_next;
    logic               last_result_reg, last_result_next;

    logic in_acc;
    logic out_acc;
    logic store_full;
    logic last_node;
    logic last_edge_idx;
    logic check_pass;

    logic [EDGE_W-1:0] edge_q;
    logic              ewr_en;
    logic [DIST_W-1:0] dist_qa, dist_qb;
    logic              dwr_en;
    logic [NAW-1:0]    dwr_addr;
    logic [DIST_W-1:0] dwr_data;
    logic [NAW-1:0]    drd_addr_a, drd_addr_b;
    relax_t            rlx;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign store_full = (edge_total_reg == ECW'(MAX_EDGES));
    assign last_node = (k_reg == nodes_reg - NODE_CW'(1));
    assign last_edge_idx = ((e_reg + ECW'(1)) == edge_total_reg);
    assign check_pass = (pass_reg == nodes_reg - NODE_CW'(1));

    bf_edge_mem #(
        .DEPTH(MAX_EDGES),
        .AW(EAW)
    ) u_edge_mem (
        .clk(clk),
        .wr_en(ewr_en),
        .wr_addr(edge_total_reg[EAW-1:0]),
        .wr_data({edge_source, edge_target, edge_weight}),
        .rd_addr(e_reg[EAW-1:0]),
        .rd_data(edge_q)
    );

    bf_dist_mem #(
        .DEPTH(MAX_NODES),
        .AW(NAW)
    ) u_dist_mem (
        .clk(clk),
        .wr_en(dwr_en),
        .wr_addr(dwr_addr),
        .wr_data(dwr_data),
        .rd_addr_a(drd_addr_a),
        .rd_addr_b(drd_addr_b),
        .rd_data_a(dist_qa),
        .rd_data_b(dist_qb)
    );

    bf_relax u_relax (
        .edge_word(edge_q),
        .dist_src(dist_qa),
        .dist_dst(dist_qb),
        .nodes(nodes_reg),
        .result(rlx)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc && last_edge)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (last_node)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_DREAD;
            end
            S_DREAD:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (check_pass && rlx.relax)
                begin
                    state_next = S_SEND;
                end
                else if (last_edge_idx && check_pass)
                begin
                    state_next = S_ORD;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            S_ORD:
            begin
                state_next = S_OLOAD;
            end
            S_OLOAD:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_acc)
                begin
                    state_next = last_result_reg ? S_LOAD : S_ORD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Handshake and memory strobes.
    always_comb
    begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        ewr_en = 1'b0;
        dwr_en = 1'b0;
        dwr_addr = k_reg[NAW-1:0];
        dwr_data = {(k_reg == '0), {DIST_VW{1'b0}}};
        drd_addr_a = edge_q[SRC_LSB +: NAW];
        drd_addr_b = edge_q[DST_LSB +: NAW];
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                ewr_en = in_valid && !store_full;
            end
            S_INIT:
            begin
                dwr_en = 1'b1;
            end
            S_UPDATE:
            begin
                dwr_en = rlx.relax && !check_pass;
                dwr_addr = edge_q[DST_LSB +: NAW];
                dwr_data = {1'b1, rlx.cand};
            end
            S_ORD:
            begin
                drd_addr_a = k_reg[NAW-1:0];
            end
            S_SEND:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Counters, configuration and result register.
    always_comb
    begin
        node_count_next = node_count_reg;
        nodes_next = nodes_reg;
        k_next = k_reg;
        pass_next = pass_reg;
        edge_total_next = edge_total_reg;
        e_next = e_reg;
        overflow_next = overflow_reg;
        node_index_next = node_index_reg;
        distance_next = distance_reg;
        reachable_next = reachable_reg;
        cycle_next = cycle_reg;
        last_result_next = last_result_reg;

        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (store_full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        edge_total_next = edge_total_reg + ECW'(1);
                    end
                    if (last_edge)
                    begin
                        if (node_count_reg == '0)
                        begin
                            nodes_next = NODE_CW'(1);
                        end
                        else if (node_count_reg > NODE_CW'(MAX_NODES))
                        begin
                            nodes_next = NODE_CW'(MAX_NODES);
                        end
                        else
                        begin
                            nodes_next = node_count_reg;
                        end
                        k_next = '0;
                    end
                end
            end
            S_INIT:
            begin
                k_next = k_reg + NODE_CW'(1);
                if (last_node)
                begin
                    e_next = '0;
                    pass_next = '0;
                end
            end
            S_UPDATE:
            begin
                if (check_pass && rlx.relax)
                begin
                    node_index_next = '0;
                    distance_next = '0;
                    reachable_next = 1'b0;
                    cycle_next = 1'b1;
                    last_result_next = 1'b1;
                end
                else if (last_edge_idx)
                begin
                    e_next = '0;
                    pass_next = pass_reg + NODE_CW'(1);
                    k_next = '0;
                end
                else
                begin
                    e_next = e_reg + ECW'(1);
                end
            end
            S_OLOAD:
            begin
                node_index_next = k_reg[NODE_FW-1:0];
                distance_next = dist_qa[DIST_VW] ? dist_qa[DIST_VW-1:0] : DIST_MAX;
                reachable_next = dist_qa[DIST_VW];
                cycle_next = 1'b0;
                last_result_next = last_node;
            end
            S_SEND:
            begin
                if (out_acc)
                begin
                    k_next = k_reg + NODE_CW'(1);
                    if (last_result_reg)
                    begin
                        // The run is over: empty the edge store for the next graph.
                        edge_total_next = '0;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            node_count_reg <= NODE_CW'(64);
            nodes_reg <= NODE_CW'(1);
            k_reg <= '0;
            pass_reg <= '0;
            edge_total_reg <= '0;
            e_reg <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_count_reg <= node_count_next;
            nodes_reg <= nodes_next;
            k_reg <= k_next;
            pass_reg <= pass_next;
            edge_total_reg <= edge_total_next;
            e_reg <= e_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_index_reg <= node_index_next;
        distance_reg <= distance_next;
        reachable_reg <= reachable_next;
        cycle_reg <= cycle_next;
        last_result_reg <= last_result_next;
    end

    assign cfg_ready = 1'b1;
    assign node_index = node_index_reg;
    assign distance = distance_reg;
    assign reachable = reachable_reg;
    assign negative_cycle = cycle_reg;
    assign edges_dropped = overflow_reg;
    assign last_result = last_result_reg;

endmodule

`default_nettype wire

### hdl/bf_check.sv
// Port-level checks for the shortest path block and their binding.
`timescale 1ns / 1ps
`default_nettype none

module bf_check
    import bf_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_ready,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic [NODE_FW-1:0]   node_index,
    input wire logic [DIST_VW-1:0]   distance,
    input wire logic                 reachable,
    input wire logic                 negative_cycle,
    input wire logic                 last_result
);

    // No edge request is taken while results of a run are still pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // A cycle report is the only and final result of its run.
    a_cycle_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && negative_cycle |-> last_result && !reachable
            && node_index == '0 && distance == '0)
        else $error("malformed negative cycle result");

    // Unreachable nodes report the largest distance.
    a_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !negative_cycle && !reachable |-> distance == DIST_MAX)
        else $error("unreachable node with wrong distance");

    // More results follow a non-final one, so inputs stay blocked.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_result |=> !in_ready)
        else $error("input reopened before the final result");

    // A stalled result stays valid and holds its distance, node index and last flag.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance)
            && $stable(node_index) && $stable(last_result))
        else $error("stalled result changed");

endmodule

bind bellman_ford_negative_cycle bf_check u_bf_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .node_index(node_index),
    .distance(distance),
    .reachable(reachable),
    .negative_cycle(negative_cycle),
    .last_result(last_result)
);

`default_nettype wire
